// ===== sv/ll1rc_pkg.sv =====
// ----------------------------------------------------------------------------
// ll1rc_pkg: shared types and tables for the LL(1) regex syntax checker
// Symbol codes, status codes, controller states, the command and status
// records between controller and datapath, and the prediction table.
// ----------------------------------------------------------------------------
`default_nettype none

package ll1rc_pkg;

    typedef enum logic [3:0] {
        SY_END  = 4'd0,
        SY_E    = 4'd1,
        SY_ET   = 4'd2,
        SY_C    = 4'd3,
        SY_CT   = 4'd4,
        SY_S    = 4'd5,
        SY_ST   = 4'd6,
        SY_A    = 4'd7,
        SY_BAR  = 4'd8,
        SY_DOT  = 4'd9,
        SY_STAR = 4'd10,
        SY_LP   = 4'd11,
        SY_RP   = 4'd12,
        SY_LET  = 4'd13,
        SY_BAD  = 4'd14
    } sym_t;

    typedef enum logic [1:0] {
        STS_PEND = 2'd0,
        STS_ACC  = 2'd1,
        STS_ERR  = 2'd2,
        STS_OVF  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        D_ACC,
        D_ERR,
        D_OVF,
        D_MATCH,
        D_EMPTY,
        D_EXPAND
    } dec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT0,
        ST_INIT1,
        ST_FETCH,
        ST_DECIDE,
        ST_PUSH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic    cap_in;
        logic    init0;
        logic    init1;
        logic    rd_top;
        logic    pop;
        logic    latch_rhs;
        logic    push;
        logic    res_load;
        status_t res_code;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        dec_t dec;
        logic push_last;
    } dp_stat_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] n;
        sym_t       r0;
        sym_t       r1;
        sym_t       r2;
    } pred_t;

    localparam logic [7:0] CH_BAR  = 8'h7C;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_LP   = 8'h28;
    localparam logic [7:0] CH_RP   = 8'h29;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;

    function automatic sym_t classify(input logic [7:0] ch);
        sym_t s;
        if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
            s = SY_LET;
        end
        else if (ch == CH_BAR) begin
            s = SY_BAR;
        end
        else if (ch == CH_DOT) begin
            s = SY_DOT;
        end
        else if (ch == CH_STAR) begin
            s = SY_STAR;
        end
        else if (ch == CH_LP) begin
            s = SY_LP;
        end
        else if (ch == CH_RP) begin
            s = SY_RP;
        end
        else begin
            s = SY_BAD;
        end
        return s;
    endfunction

    // Right-hand side in left-to-right order; empty productions are
    // chosen on the follow set of their nonterminal.
    function automatic pred_t predict(input sym_t nt, input sym_t la);
        pred_t p;
        logic  starts;
        starts = (la == SY_LP) || (la == SY_LET);
        p.ok = 1'b0;
        p.n  = 2'd0;
        p.r0 = SY_END;
        p.r1 = SY_END;
        p.r2 = SY_END;
        unique case (nt)
            SY_E: begin
                if (starts) begin
                    p.ok = 1'b1; p.n = 2'd2; p.r0 = SY_C; p.r1 = SY_ET;
                end
            end
            SY_ET: begin
                if (la == SY_BAR) begin
                    p.ok = 1'b1; p.n = 2'd2; p.r0 = SY_BAR; p.r1 = SY_E;
                end
                else if (la == SY_RP || la == SY_END) begin
                    p.ok = 1'b1;
                end
            end
            SY_C: begin
                if (starts) begin
                    p.ok = 1'b1; p.n = 2'd2; p.r0 = SY_S; p.r1 = SY_CT;
                end
            end
            SY_CT: begin
                if (la == SY_DOT) begin
                    p.ok = 1'b1; p.n = 2'd2; p.r0 = SY_DOT; p.r1 = SY_C;
                end
                else if (la == SY_BAR || la == SY_RP || la == SY_END) begin
                    p.ok = 1'b1;
                end
            end
            SY_S: begin
                if (starts) begin
                    p.ok = 1'b1; p.n = 2'd2; p.r0 = SY_A; p.r1 = SY_ST;
                end
            end
            SY_ST: begin
                if (la == SY_STAR) begin
                    p.ok = 1'b1; p.n = 2'd2; p.r0 = SY_STAR; p.r1 = SY_ST;
                end
                else if (la == SY_DOT || la == SY_BAR || la == SY_RP || la == SY_END) begin
                    p.ok = 1'b1;
                end
            end
            SY_A: begin
                if (la == SY_LP) begin
                    p.ok = 1'b1; p.n = 2'd3;
                    p.r0 = SY_LP; p.r1 = SY_E; p.r2 = SY_RP;
                end
                else if (la == SY_LET) begin
                    p.ok = 1'b1; p.n = 2'd1; p.r0 = SY_LET;
                end
            end
            default: begin
                p.ok = 1'b0;
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ll1rc_dp.sv =====
// ----------------------------------------------------------------------------
// ll1rc_dp: parser datapath
// Holds the symbol stack memory, the stack level, the lookahead, the
// pending right-hand side and the result registers, and classifies the
// top of stack against the lookahead for the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1rc_dp #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         symbol,
    input  wire logic               is_end,
    input  wire ll1rc_pkg::ctrl_cmd_t cmd,
    output ll1rc_pkg::dp_stat_t     stat,
    output logic [1:0]              status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);

    ll1rc_pkg::sym_t mem [STACK_DEPTH];

    ll1rc_pkg::sym_t    rd_data_reg;
    ll1rc_pkg::sym_t    la_reg;
    ll1rc_pkg::sym_t    la_next;
    logic [LW-1:0]      level_reg;
    logic [LW-1:0]      level_next;
    logic [LW-1:0]      level_dec;
    logic [LW:0]        grow_sum;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    ll1rc_pkg::sym_t    r0_reg;
    ll1rc_pkg::sym_t    r1_reg;
    ll1rc_pkg::sym_t    r2_reg;
    ll1rc_pkg::status_t res_reg;
    ll1rc_pkg::status_t out_reg;
    ll1rc_pkg::pred_t   pr;
    ll1rc_pkg::sym_t    push_sym;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    ll1rc_pkg::sym_t    wr_data;
    logic [AW-1:0]      rd_addr;

    assign level_dec = level_reg - LW'(1);
    assign rd_addr   = level_dec[AW-1:0];
    assign pr        = ll1rc_pkg::predict(rd_data_reg, la_reg);
    assign grow_sum  = {1'b0, level_dec} + (LW + 1)'(pr.n);
    assign la_next   = is_end ? ll1rc_pkg::SY_END : ll1rc_pkg::classify(symbol);

    always_comb begin
        unique case (cnt_reg)
            2'd3:    push_sym = r2_reg;
            2'd2:    push_sym = r1_reg;
            default: push_sym = r0_reg;
        endcase
    end

    always_comb begin
        wr_en   = cmd.init0 | cmd.init1 | cmd.push;
        wr_addr = level_reg[AW-1:0];
        wr_data = push_sym;
        if (cmd.init0) begin
            wr_addr = AW'(0);
            wr_data = ll1rc_pkg::SY_END;
        end
        else if (cmd.init1) begin
            wr_addr = AW'(1);
            wr_data = ll1rc_pkg::SY_E;
        end
    end

    always_comb begin
        stat.push_last = (cnt_reg == 2'd1);
        if (level_reg == '0 || level_reg > LW'(STACK_DEPTH)) begin
            stat.dec = ll1rc_pkg::D_ERR;
        end
        else if (rd_data_reg == ll1rc_pkg::SY_END) begin
            stat.dec = (la_reg == ll1rc_pkg::SY_END) ? ll1rc_pkg::D_ACC : ll1rc_pkg::D_ERR;
        end
        else if (rd_data_reg >= ll1rc_pkg::SY_BAR) begin
            stat.dec = (rd_data_reg == la_reg) ? ll1rc_pkg::D_MATCH : ll1rc_pkg::D_ERR;
        end
        else if (!pr.ok) begin
            stat.dec = ll1rc_pkg::D_ERR;
        end
        else if (pr.n == 2'd0) begin
            stat.dec = ll1rc_pkg::D_EMPTY;
        end
        else if (grow_sum > (LW + 1)'(STACK_DEPTH)) begin
            stat.dec = ll1rc_pkg::D_OVF;
        end
        else begin
            stat.dec = ll1rc_pkg::D_EXPAND;
        end
    end

    always_comb begin
        level_next = level_reg;
        cnt_next   = cnt_reg;
        if (cmd.init1) begin
            level_next = LW'(2);
        end
        else if (cmd.pop) begin
            level_next = level_dec;
        end
        else if (cmd.push) begin
            level_next = level_reg + LW'(1);
        end
        if (cmd.latch_rhs) begin
            cnt_next = pr.n;
        end
        else if (cmd.push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_top) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            level_reg <= '0;
            cnt_reg   <= '0;
        end
        else begin
            level_reg <= level_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.cap_in) begin
            la_reg <= la_next;
        end
        if (cmd.latch_rhs) begin
            r0_reg <= pr.r0;
            r1_reg <= pr.r1;
            r2_reg <= pr.r2;
        end
        if (cmd.res_load) begin
            res_reg <= cmd.res_code;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    assign status = out_reg;

endmodule

`default_nettype wire

// ===== sv/ll1rc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ll1rc_ctrl: parser sequencer
// Steps each item through stack reload on a start request, top fetch, decision and
// pushes, keeps the parse-finished flag and drives the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1rc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic                start_req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    input  wire ll1rc_pkg::dp_stat_t stat,
    output ll1rc_pkg::ctrl_cmd_t     cmd
);

    ll1rc_pkg::state_t state_reg;
    ll1rc_pkg::state_t state_next;
    logic              finished_reg;
    logic              finished_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ll1rc_pkg::ST_IDLE;
            finished_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        finished_next = finished_reg;
        req_ready     = 1'b0;
        cmd           = '0;
        cmd.res_code  = ll1rc_pkg::STS_ERR;
        unique case (state_reg)
            ll1rc_pkg::ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    cmd.cap_in = 1'b1;
                    if (start_req) begin
                        finished_next = 1'b0;
                        state_next    = ll1rc_pkg::ST_INIT0;
                    end
                    else if (finished_reg) begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = ll1rc_pkg::STS_ERR;
                        state_next   = ll1rc_pkg::ST_DONE;
                    end
                    else begin
                        state_next = ll1rc_pkg::ST_FETCH;
                    end
                end
            end
            ll1rc_pkg::ST_INIT0: begin
                cmd.init0  = 1'b1;
                state_next = ll1rc_pkg::ST_INIT1;
            end
            ll1rc_pkg::ST_INIT1: begin
                cmd.init1  = 1'b1;
                state_next = ll1rc_pkg::ST_FETCH;
            end
            ll1rc_pkg::ST_FETCH: begin
                cmd.rd_top = 1'b1;
                state_next = ll1rc_pkg::ST_DECIDE;
            end
            ll1rc_pkg::ST_DECIDE: begin
                unique case (stat.dec)
                    ll1rc_pkg::D_ACC: begin
                        cmd.res_load  = 1'b1;
                        cmd.res_code  = ll1rc_pkg::STS_ACC;
                        finished_next = 1'b1;
                        state_next    = ll1rc_pkg::ST_DONE;
                    end
                    ll1rc_pkg::D_OVF: begin
                        cmd.pop       = 1'b1;
                        cmd.res_load  = 1'b1;
                        cmd.res_code  = ll1rc_pkg::STS_OVF;
                        finished_next = 1'b1;
                        state_next    = ll1rc_pkg::ST_DONE;
                    end
                    ll1rc_pkg::D_MATCH: begin
                        cmd.pop      = 1'b1;
                        cmd.res_load = 1'b1;
                        cmd.res_code = ll1rc_pkg::STS_PEND;
                        state_next   = ll1rc_pkg::ST_DONE;
                    end
                    ll1rc_pkg::D_EMPTY: begin
                        cmd.pop    = 1'b1;
                        state_next = ll1rc_pkg::ST_FETCH;
                    end
                    ll1rc_pkg::D_EXPAND: begin
                        cmd.pop       = 1'b1;
                        cmd.latch_rhs = 1'b1;
                        state_next    = ll1rc_pkg::ST_PUSH;
                    end
                    default: begin
                        cmd.res_load  = 1'b1;
                        cmd.res_code  = ll1rc_pkg::STS_ERR;
                        finished_next = 1'b1;
                        state_next    = ll1rc_pkg::ST_DONE;
                    end
                endcase
            end
            ll1rc_pkg::ST_PUSH: begin
                cmd.push = 1'b1;
                if (stat.push_last) begin
                    state_next = ll1rc_pkg::ST_FETCH;
                end
            end
            ll1rc_pkg::ST_DONE: begin
                if (!out_valid_reg || rsp_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ll1rc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ll1rc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/ll1_regex_syntax_checker_core.sv =====
// A start request first reloads the stack; then the top of stack is fetched and decided on,
// and symbols are pushed, until a match, accept, overflow or error gives the result; once
// the parse is finished, an item goes straight to an error result. Items are taken only
// while idle, even while a result waits; a later result holds until that one is taken.
// Reset (rst_n, asynchronous, active low) empties the stack, marks the parse as
// finished and drops the result valid; stack contents are undefined until written.
// ----------------------------------------------------------------------------
// ll1_regex_syntax_checker_core: LL(1) regular-expression syntax checker
// Takes one character or end marker per transfer and returns the parse
// status for it, using a symbol stack expanded through a prediction table.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1_regex_syntax_checker_core #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire logic       start_req,
    input  wire logic [7:0] symbol,
    input  wire logic       is_end,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output logic [1:0]      status
);

    ll1rc_pkg::ctrl_cmd_t cmd;
    ll1rc_pkg::dp_stat_t  stat;

    ll1rc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .start_req (start_req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ll1rc_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .symbol (symbol),
        .is_end (is_end),
        .cmd    (cmd),
        .stat   (stat),
        .status (status)
    );

endmodule

`default_nettype wire

// ===== sv/ll1rc_checker.sv =====
// ----------------------------------------------------------------------------
// ll1rc_checker: port-level checks for the syntax checker core
// Tracks outstanding items and checks result ordering, bounds and the
// output hold rule, then binds itself to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ll1rc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       req_valid,
    input wire logic       req_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] status
);

    logic [1:0] outstanding_reg;
    logic [1:0] outstanding_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = req_valid && req_ready;
    assign out_xfer = rsp_valid && rsp_ready;

    always_comb begin
        outstanding_next = outstanding_reg;
        if (in_xfer && !out_xfer) begin
            outstanding_next = outstanding_reg + 2'd1;
        end
        else if (out_xfer && !in_xfer) begin
            outstanding_next = outstanding_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            outstanding_reg <= '0;
        end
        else begin
            outstanding_reg <= outstanding_next;
        end
    end

    // A result is only ever shown for an item that was taken in.
    a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> outstanding_reg != 2'd0)
        else $error("result shown with no outstanding item");

    // At most one item in work and one result waiting.
    a_outstanding_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg != 2'd3)
        else $error("more than two items outstanding");

    // No new item is taken while two are already outstanding.
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 2'd2 |-> !req_ready)
        else $error("item taken while two are outstanding");

    // A stalled result holds its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
        else $error("stalled result changed");

endmodule

bind ll1_regex_syntax_checker_core ll1rc_checker u_ll1rc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status)
);

`default_nettype wire
